// ----- sv/was_pkg.sv -----
// was_pkg: field widths, mode and register codes, and the inter-module tag
// type of the wake alarm scheduler. No dependencies.
package was_pkg;

    // Field widths
    localparam int NOW_W         = 32;
    localparam int MODE_W        = 2;
    localparam int INTERVAL_W    = 16;
    localparam int ANCHOR_W      = 32;
    localparam int HOUR_W        = 5;
    localparam int MINUTE_W      = 6;
    localparam int SEC_BYTE_W    = 7;
    localparam int MIN_BYTE_W    = 7;
    localparam int HOUR_BYTE_W   = 6;

    // Configuration channel
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ANCHOR   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOUR     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MINUTE   = 3'd4;

    // Schedule modes; the fourth code is rejected
    localparam logic [MODE_W-1:0] MODE_SYNC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RESCUE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DAILY  = 2'd2;

    // Time constants
    localparam int SECS_PER_DAY  = 86400;
    localparam int PRE_WAKE      = 10;
    localparam int NEAR_WINDOW   = 5;

    // Period in seconds (65535 min * 60 < 2^22), time of day (< 2^17)
    localparam int PERIOD_W      = 22;
    localparam int TOD_W         = 17;
    localparam int DAY_OFF_W     = 17;

    // Alarm instant and its verdict, carried alongside the time-of-day stages
    typedef struct packed {
        logic             ok;
        logic [NOW_W-1:0] t;
    } was_tag_t;

endpackage

// ----- sv/was_in_if.sv -----
// was_in_if: timestamp input channel (valid/ready plus current Unix time).
// Depends on was_pkg.
interface was_in_if import was_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [NOW_W-1:0] now_seconds;

    modport source (output valid, output now_seconds, input ready);
    modport sink   (input valid, input now_seconds, output ready);
endinterface

// ----- sv/was_out_if.sv -----
// was_out_if: alarm result channel (valid/ready plus alarm fields).
// Depends on was_pkg.
interface was_out_if import was_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [NOW_W-1:0]       alarm_time;
    logic [SEC_BYTE_W-1:0]  seconds_byte;
    logic [MIN_BYTE_W-1:0]  minutes_byte;
    logic [HOUR_BYTE_W-1:0] hours_byte;
    logic                   scheduled;

    modport source (output valid, output alarm_time, output seconds_byte,
                    output minutes_byte, output hours_byte, output scheduled,
                    input ready);
    modport sink   (input valid, input alarm_time, input seconds_byte,
                    input minutes_byte, input hours_byte, input scheduled,
                    output ready);
endinterface

// ----- sv/was_cfg_if.sv -----
// was_cfg_if: configuration write channel (valid/ready, register index, data).
// Depends on was_pkg.
interface was_cfg_if import was_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/was_div.sv -----
// was_div: pipelined restoring remainder unit, STEP dividend bits per stage,
// with a tag that travels alongside. Stand-alone, no package needed.
module was_div #(
    parameter int DIVIDEND_W = 32,
    parameter int DIVISOR_W  = 22,
    parameter int TAG_W      = 1,
    parameter int STEP       = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DIVIDEND_W-1:0] in_dividend,
    input  logic [DIVISOR_W-1:0]  in_divisor,
    input  logic [TAG_W-1:0]      in_tag,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DIVISOR_W-1:0]  out_rem,
    output logic [TAG_W-1:0]      out_tag
);

    localparam int NSTG = DIVIDEND_W / STEP;

    logic                  v_reg       [NSTG];
    logic [DIVISOR_W-1:0]  rem_reg     [NSTG];
    logic [DIVIDEND_W-1:0] dvd_reg     [NSTG];
    logic [DIVISOR_W-1:0]  dvs_reg     [NSTG];
    logic [TAG_W-1:0]      tag_reg     [NSTG];
    logic                  stage_ready [NSTG+1];

    assign stage_ready[NSTG] = out_ready;
    assign in_ready          = stage_ready[0];

    for (genvar k = 0; k < NSTG; k++)
    begin : g_stage
        logic                  src_valid;
        logic [DIVISOR_W-1:0]  src_rem;
        logic [DIVIDEND_W-1:0] src_dvd;
        logic [DIVISOR_W-1:0]  src_dvs;
        logic [TAG_W-1:0]      src_tag;
        logic [DIVISOR_W-1:0]  rem_next;
        logic [DIVIDEND_W-1:0] dvd_next;
        logic [DIVISOR_W:0]    trial;

        // Stage source: the input port or the previous stage
        if (k == 0)
        begin : g_first
            assign src_valid = in_valid;
            assign src_rem   = '0;
            assign src_dvd   = in_dividend;
            assign src_dvs   = in_divisor;
            assign src_tag   = in_tag;
        end
        else
        begin : g_rest
            assign src_valid = v_reg[k-1];
            assign src_rem   = rem_reg[k-1];
            assign src_dvd   = dvd_reg[k-1];
            assign src_dvs   = dvs_reg[k-1];
            assign src_tag   = tag_reg[k-1];
        end

        // Shift in STEP dividend bits, subtracting the divisor after each if it fits
        always_comb
        begin
            rem_next = src_rem;
            dvd_next = src_dvd;
            trial    = '0;
            for (int j = 0; j < STEP; j++)
            begin
                trial    = {rem_next, dvd_next[DIVIDEND_W-1]};
                dvd_next = {dvd_next[DIVIDEND_W-2:0], 1'b0};
                if (trial >= {1'b0, src_dvs})
                begin
                    trial = trial - {1'b0, src_dvs};
                end
                rem_next = trial[DIVISOR_W-1:0];
            end
        end

        // A stage moves when it is empty or its successor moves
        assign stage_ready[k] = !v_reg[k] || stage_ready[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (stage_ready[k])
            begin
                v_reg[k] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_ready[k])
            begin
                rem_reg[k] <= rem_next;
                dvd_reg[k] <= dvd_next;
                dvs_reg[k] <= src_dvs;
                tag_reg[k] <= src_tag;
            end
        end
    end

    assign out_valid = v_reg[NSTG-1];
    assign out_rem   = rem_reg[NSTG-1];
    assign out_tag   = tag_reg[NSTG-1];

endmodule

// ----- sv/was_tod.sv -----
// was_tod: splits a time of day into hours, minutes and seconds and packs them
// as BCD alarm bytes, five register stages. Depends on was_pkg, was_out_if.
module was_tod import was_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [TOD_W-1:0] in_tod,
    input  was_tag_t         in_tag,
    was_out_if.source        alarm
);

    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;
    // floor(2^22/3600) and floor(2^16/60): quotient is exact or one short
    localparam int RECIP_HOUR    = 1165;
    localparam int RECIP_HOUR_SH = 22;
    localparam int RECIP_MIN     = 1092;
    localparam int RECIP_MIN_SH  = 16;
    localparam int HPROD_W       = TOD_W + 11;
    localparam int HQ_W          = 5;
    localparam int HREM0_W       = 13;
    localparam int HREM_W        = 12;
    localparam int MPROD_W       = HREM_W + 11;
    localparam int MQ_W          = 6;
    localparam int MREM0_W       = 7;

    // Values below 60 to packed BCD (tens in bits 6:4)
    function automatic logic [6:0] bcd_of(input logic [5:0] v);
        logic [2:0] tens;
        logic [3:0] ones;
        if (v >= 6'd50)
            tens = 3'd5;
        else if (v >= 6'd40)
            tens = 3'd4;
        else if (v >= 6'd30)
            tens = 3'd3;
        else if (v >= 6'd20)
            tens = 3'd2;
        else if (v >= 6'd10)
            tens = 3'd1;
        else
            tens = 3'd0;
        ones = 4'(v - 6'(tens) * 6'd10);
        return {tens, ones};
    endfunction

    logic               t1_v_reg, t2_v_reg, t3_v_reg, t4_v_reg, o_v_reg;
    logic               t1_ready, t2_ready, t3_ready, t4_ready, o_ready;

    logic [TOD_W-1:0]   t1_tod_reg;
    logic [HQ_W-1:0]    t1_qh_reg;
    was_tag_t           t1_tag_reg;

    logic [HREM0_W-1:0] t2_hrem_reg;
    logic [HQ_W-1:0]    t2_qh_reg;
    was_tag_t           t2_tag_reg;

    logic [HREM_W-1:0]  t3_rem_reg;
    logic [HQ_W-1:0]    t3_h_reg;
    logic [MQ_W-1:0]    t3_qm_reg;
    was_tag_t           t3_tag_reg;

    logic [MREM0_W-1:0] t4_mrem_reg;
    logic [HQ_W-1:0]    t4_h_reg;
    logic [MQ_W-1:0]    t4_qm_reg;
    was_tag_t           t4_tag_reg;

    logic [NOW_W-1:0]       o_time_reg;
    logic [SEC_BYTE_W-1:0]  o_sec_reg;
    logic [MIN_BYTE_W-1:0]  o_min_reg;
    logic [HOUR_BYTE_W-1:0] o_hour_reg;
    logic                   o_ok_reg;

    logic [HPROD_W-1:0] hprod;
    logic [HQ_W-1:0]    t1_qh_next;
    logic [HREM0_W-1:0] t2_hrem_next;
    logic               h_over;
    logic [HQ_W-1:0]    t3_h_next;
    logic [HREM_W-1:0]  t3_rem_next;
    logic [MPROD_W-1:0] mprod;
    logic [MQ_W-1:0]    t3_qm_next;
    logic [MREM0_W-1:0] t4_mrem_next;
    logic               m_over;
    logic [MQ_W-1:0]    min_val;
    logic [MQ_W-1:0]    sec_val;
    logic [6:0]         hour_bcd;

    // Ready chain: a stage moves when empty or its successor moves
    assign o_ready  = !o_v_reg  || alarm.ready;
    assign t4_ready = !t4_v_reg || o_ready;
    assign t3_ready = !t3_v_reg || t4_ready;
    assign t2_ready = !t2_v_reg || t3_ready;
    assign t1_ready = !t1_v_reg || t2_ready;
    assign in_ready = t1_ready;

    // Stage 1: hour estimate by reciprocal
    assign hprod      = HPROD_W'(in_tod) * HPROD_W'(RECIP_HOUR);
    assign t1_qh_next = hprod[RECIP_HOUR_SH +: HQ_W];

    // Stage 2: remainder of the hour estimate
    assign t2_hrem_next = HREM0_W'(t1_tod_reg
                                   - TOD_W'(t1_qh_reg) * TOD_W'(SECS_PER_HOUR));

    // Stage 3: hour correction, minute estimate
    assign h_over      = t2_hrem_reg >= HREM0_W'(SECS_PER_HOUR);
    assign t3_h_next   = h_over ? t2_qh_reg + HQ_W'(1) : t2_qh_reg;
    assign t3_rem_next = h_over ? HREM_W'(t2_hrem_reg - HREM0_W'(SECS_PER_HOUR))
                                : HREM_W'(t2_hrem_reg);
    assign mprod       = MPROD_W'(t3_rem_next) * MPROD_W'(RECIP_MIN);
    assign t3_qm_next  = mprod[RECIP_MIN_SH +: MQ_W];

    // Stage 4: remainder of the minute estimate
    assign t4_mrem_next = MREM0_W'(t3_rem_reg - HREM_W'(t3_qm_reg) * HREM_W'(SECS_PER_MIN));

    // Stage 5: minute correction and BCD packing
    assign m_over   = t4_mrem_reg >= MREM0_W'(SECS_PER_MIN);
    assign min_val  = m_over ? t4_qm_reg + MQ_W'(1) : t4_qm_reg;
    assign sec_val  = m_over ? MQ_W'(t4_mrem_reg - MREM0_W'(SECS_PER_MIN))
                             : MQ_W'(t4_mrem_reg);
    assign hour_bcd = bcd_of(MQ_W'(t4_h_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_v_reg <= 1'b0;
            t2_v_reg <= 1'b0;
            t3_v_reg <= 1'b0;
            t4_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else
        begin
            if (t1_ready) t1_v_reg <= in_valid;
            if (t2_ready) t2_v_reg <= t1_v_reg;
            if (t3_ready) t3_v_reg <= t2_v_reg;
            if (t4_ready) t4_v_reg <= t3_v_reg;
            if (o_ready)  o_v_reg  <= t4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (t1_ready)
        begin
            t1_tod_reg <= in_tod;
            t1_qh_reg  <= t1_qh_next;
            t1_tag_reg <= in_tag;
        end
        if (t2_ready)
        begin
            t2_hrem_reg <= t2_hrem_next;
            t2_qh_reg   <= t1_qh_reg;
            t2_tag_reg  <= t1_tag_reg;
        end
        if (t3_ready)
        begin
            t3_rem_reg <= t3_rem_next;
            t3_h_reg   <= t3_h_next;
            t3_qm_reg  <= t3_qm_next;
            t3_tag_reg <= t2_tag_reg;
        end
        if (t4_ready)
        begin
            t4_mrem_reg <= t4_mrem_next;
            t4_h_reg    <= t3_h_reg;
            t4_qm_reg   <= t3_qm_reg;
            t4_tag_reg  <= t3_tag_reg;
        end
        if (o_ready)
        begin
            o_time_reg <= t4_tag_reg.t;
            o_sec_reg  <= bcd_of(sec_val);
            o_min_reg  <= bcd_of(min_val);
            o_hour_reg <= hour_bcd[HOUR_BYTE_W-1:0];
            o_ok_reg   <= t4_tag_reg.ok;
        end
    end

    // Rejected items carry time zero, so their bytes are zero as well
    assign alarm.valid        = o_v_reg;
    assign alarm.alarm_time   = o_time_reg;
    assign alarm.seconds_byte = o_sec_reg;
    assign alarm.minutes_byte = o_min_reg;
    assign alarm.hours_byte   = o_hour_reg;
    assign alarm.scheduled    = o_ok_reg;

endmodule

// ----- sv/wake_alarm_scheduler.sv -----
// wake_alarm_scheduler: top level; configuration registers, slot arithmetic,
// the slot remainder pipeline and the day remainder. Depends on was_pkg, the
// channel interfaces, was_div and was_tod.
//
//   channel    | dir | modport | transaction
//   -----------+-----+---------+--------------------------------------------
//   cfg        | in  | sink    | register index and write data
//   timestamp  | in  | sink    | now_seconds
//   alarm      | out | source  | alarm_time, BCD bytes, scheduled flag
//
// One timestamp is accepted per cycle unless the pipeline is stalled; each
// gives one alarm transaction after stage A, the slot remainder pipeline
// that retires DIV_STEP dividend bits per stage, stages B to H and was_tod.
// Every stage holds its valid bit and moves only when empty or when its
// successor moves, so a stalled alarm channel fills bubbles before it
// blocks timestamp. Reset clears the configuration registers and all valid
// bits; there is no clearing pass. Configuration writes are always taken.
module wake_alarm_scheduler import was_pkg::*; #(
    parameter int DIV_STEP = 2
) (
    input  logic     clk,
    input  logic     rst_n,
    was_cfg_if.sink  cfg,
    was_in_if.sink   timestamp,
    was_out_if.source alarm
);

    localparam int HOUR_SECS = 3600;
    localparam int MIN_SECS  = 60;
    // floor(2^32/86400): day quotient is exact or one short
    localparam int DAY_RECIP    = 49710;
    localparam int DAY_RECIP_SH = 32;
    localparam int DQ_W         = 16;
    localparam int DPROD_W      = NOW_W + DQ_W;
    localparam int DREM_W       = 18;

    // Configuration registers and values derived from them
    logic [MODE_W-1:0]     mode_reg;
    logic [INTERVAL_W-1:0] interval_reg;
    logic [ANCHOR_W-1:0]   anchor_reg;
    logic [HOUR_W-1:0]     hour_reg;
    logic [MINUTE_W-1:0]   minute_reg;
    logic [PERIOD_W-1:0]   period_reg;
    logic [PERIOD_W-1:0]   period_next;
    logic                  use_anchor_reg;
    logic                  use_anchor_next;
    logic [DAY_OFF_W-1:0]  day_off_reg;
    logic [DAY_OFF_W-1:0]  day_off_next;
    logic [NOW_W-1:0]      period32;

    // Pipeline stages around the divider
    logic             a_v_reg, b_v_reg, c_v_reg, d_v_reg, e_v_reg;
    logic             a_ready, b_ready, c_ready, d_ready, e_ready;
    logic [NOW_W-1:0] a_now_reg, a_dvd_reg, a_dvd_next;
    logic [NOW_W-1:0] b_now_reg, b_base_reg, b_base_next;
    logic             b_early_reg, b_early_next;
    logic [NOW_W-1:0] c_now_reg, c_slot_reg, c_slot_next, c_day_reg, c_day_next;
    logic [NOW_W-1:0] d_now_reg, d_slot_reg, d_slot_next, d_day_reg, d_day_next;
    logic [NOW_W-1:0] e_t_reg, e_t_next;
    logic             e_ok_reg, e_ok_next;
    logic [NOW_W-1:0] near_limit, sync_slot;

    logic                 d1_in_ready, d1_valid;
    logic [PERIOD_W-1:0]  d1_divisor, d1_rem;
    logic [NOW_W-1:0]     d1_now;

    // Day remainder stages
    logic                 f_v_reg, g_v_reg, h_v_reg;
    logic                 f_ready, g_ready, h_ready, tod_ready;
    logic [DPROD_W-1:0]   dprod;
    logic [DQ_W-1:0]      f_q_next, f_q_reg;
    was_tag_t             f_tag_reg, g_tag_reg, h_tag_reg;
    logic [DREM_W-1:0]    g_rem_next, g_rem_reg;
    logic [TOD_W-1:0]     h_tod_next, h_tod_reg;

    // Register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_SYNC;
            interval_reg   <= '0;
            anchor_reg     <= '0;
            hour_reg       <= '0;
            minute_reg     <= '0;
            period_reg     <= '0;
            use_anchor_reg <= 1'b0;
            day_off_reg    <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_MODE:     mode_reg     <= cfg.data[MODE_W-1:0];
                    CFG_INTERVAL: interval_reg <= cfg.data[INTERVAL_W-1:0];
                    CFG_ANCHOR:   anchor_reg   <= cfg.data[ANCHOR_W-1:0];
                    CFG_HOUR:     hour_reg     <= cfg.data[HOUR_W-1:0];
                    CFG_MINUTE:   minute_reg   <= cfg.data[MINUTE_W-1:0];
                    default:      ;
                endcase
            end
            period_reg     <= period_next;
            use_anchor_reg <= use_anchor_next;
            day_off_reg    <= day_off_next;
        end
    end

    // Period in seconds as 64x - 4x; daily offset from the start of the day
    assign period_next     = PERIOD_W'({interval_reg, 6'b0}) - PERIOD_W'({interval_reg, 2'b0});
    assign use_anchor_next = (anchor_reg != '0) && (interval_reg != '0);
    assign day_off_next    = DAY_OFF_W'(hour_reg) * DAY_OFF_W'(HOUR_SECS)
                           + DAY_OFF_W'(minute_reg) * DAY_OFF_W'(MIN_SECS);
    assign period32        = NOW_W'(period_reg);

    // Ready chain
    assign a_ready         = !a_v_reg || d1_in_ready;
    assign b_ready         = !b_v_reg || c_ready;
    assign c_ready         = !c_v_reg || d_ready;
    assign d_ready         = !d_v_reg || e_ready;
    assign e_ready         = !e_v_reg || f_ready;
    assign f_ready         = !f_v_reg || g_ready;
    assign g_ready         = !g_v_reg || h_ready;
    assign h_ready         = !h_v_reg || tod_ready;
    assign timestamp.ready = a_ready;

    // Stage A: dividend is now (daily) or the distance from the anchor
    assign a_dvd_next = (mode_reg == MODE_DAILY) ? timestamp.now_seconds
                                                 : timestamp.now_seconds - anchor_reg;
    assign d1_divisor = (mode_reg == MODE_DAILY) ? PERIOD_W'(SECS_PER_DAY) : period_reg;

    was_div #(
        .DIVIDEND_W (NOW_W),
        .DIVISOR_W  (PERIOD_W),
        .TAG_W      (NOW_W),
        .STEP       (DIV_STEP)
    ) u_slot_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (a_v_reg),
        .in_ready    (d1_in_ready),
        .in_dividend (a_dvd_reg),
        .in_divisor  (d1_divisor),
        .in_tag      (a_now_reg),
        .out_valid   (d1_valid),
        .out_ready   (b_ready),
        .out_rem     (d1_rem),
        .out_tag     (d1_now)
    );

    // Stage B: now less remainder (slot base or start of day)
    assign b_base_next  = d1_now - NOW_W'(d1_rem);
    assign b_early_next = d1_now < anchor_reg;

    // Stage C: aligned slot and today's daily instant
    assign c_slot_next = use_anchor_reg ? (b_early_reg ? anchor_reg : b_base_reg + period32)
                                        : b_now_reg + period32;
    assign c_day_next  = b_base_reg + NOW_W'(day_off_reg);

    // Stage D: pre-wake, and roll the daily instant to tomorrow if passed
    assign d_slot_next = (c_slot_reg > NOW_W'(PRE_WAKE)) ? c_slot_reg - NOW_W'(PRE_WAKE)
                                                         : c_slot_reg;
    assign d_day_next  = (c_day_reg <= c_now_reg) ? c_day_reg + NOW_W'(SECS_PER_DAY)
                                                  : c_day_reg;

    // Stage E: push a near slot one period on, then pick by mode
    assign near_limit = d_now_reg + NOW_W'(NEAR_WINDOW);
    assign sync_slot  = (d_slot_reg <= near_limit) ? d_slot_reg + period32 : d_slot_reg;

    always_comb
    begin
        e_t_next  = '0;
        e_ok_next = 1'b0;
        unique case (mode_reg)
            MODE_SYNC:
            begin
                e_t_next  = sync_slot;
                e_ok_next = 1'b1;
            end
            MODE_RESCUE:
            begin
                e_ok_next = interval_reg != '0;
                e_t_next  = e_ok_next ? d_now_reg + period32 : '0;
            end
            MODE_DAILY:
            begin
                e_t_next  = d_day_reg;
                e_ok_next = 1'b1;
            end
            default:
            begin
                e_t_next  = '0;
                e_ok_next = 1'b0;
            end
        endcase
    end

    // Stage F: day quotient estimate by reciprocal
    assign dprod    = DPROD_W'(e_t_reg) * DPROD_W'(DAY_RECIP);
    assign f_q_next = dprod[DAY_RECIP_SH +: DQ_W];

    // Stage G: remainder of the estimate, below two days so 18 bits hold it
    assign g_rem_next = DREM_W'(f_tag_reg.t) - DREM_W'(f_q_reg) * DREM_W'(SECS_PER_DAY);

    // Stage H: correct a quotient that came out one short
    assign h_tod_next = (g_rem_reg >= DREM_W'(SECS_PER_DAY))
                      ? TOD_W'(g_rem_reg - DREM_W'(SECS_PER_DAY))
                      : TOD_W'(g_rem_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
            h_v_reg <= 1'b0;
        end
        else
        begin
            if (a_ready) a_v_reg <= timestamp.valid;
            if (b_ready) b_v_reg <= d1_valid;
            if (c_ready) c_v_reg <= b_v_reg;
            if (d_ready) d_v_reg <= c_v_reg;
            if (e_ready) e_v_reg <= d_v_reg;
            if (f_ready) f_v_reg <= e_v_reg;
            if (g_ready) g_v_reg <= f_v_reg;
            if (h_ready) h_v_reg <= g_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready)
        begin
            a_now_reg <= timestamp.now_seconds;
            a_dvd_reg <= a_dvd_next;
        end
        if (b_ready)
        begin
            b_now_reg   <= d1_now;
            b_base_reg  <= b_base_next;
            b_early_reg <= b_early_next;
        end
        if (c_ready)
        begin
            c_now_reg  <= b_now_reg;
            c_slot_reg <= c_slot_next;
            c_day_reg  <= c_day_next;
        end
        if (d_ready)
        begin
            d_now_reg  <= c_now_reg;
            d_slot_reg <= d_slot_next;
            d_day_reg  <= d_day_next;
        end
        if (e_ready)
        begin
            e_t_reg  <= e_t_next;
            e_ok_reg <= e_ok_next;
        end
        if (f_ready)
        begin
            f_q_reg      <= f_q_next;
            f_tag_reg.ok <= e_ok_reg;
            f_tag_reg.t  <= e_t_reg;
        end
        if (g_ready)
        begin
            g_rem_reg <= g_rem_next;
            g_tag_reg <= f_tag_reg;
        end
        if (h_ready)
        begin
            h_tod_reg <= h_tod_next;
            h_tag_reg <= g_tag_reg;
        end
    end

    // Time of day of the alarm instant
    was_tod u_tod (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (h_v_reg),
        .in_ready (tod_ready),
        .in_tod   (h_tod_reg),
        .in_tag   (h_tag_reg),
        .alarm    (alarm)
    );

endmodule

// ----- verif/wake_alarm_scheduler_tb.sv -----
// wake_alarm_scheduler_tb: self-checking testbench for the wake alarm scheduler.
// Drives timestamps and register writes, predicts every alarm transaction and
// checks it. Depends on was_pkg, the three channel interfaces and the top level.
module wake_alarm_scheduler_tb import was_pkg::*; ;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int MAX_IDLE      = 11;
    localparam int DRAIN_CYCLES  = 60;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RAND_PHASES   = 25;
    localparam int PHASE_ITEMS   = 80;

    typedef struct packed {
        logic [NOW_W-1:0]       alarm_time;
        logic [SEC_BYTE_W-1:0]  seconds_byte;
        logic [MIN_BYTE_W-1:0]  minutes_byte;
        logic [HOUR_BYTE_W-1:0] hours_byte;
        logic                   scheduled;
    } alarm_fields_t;

    logic clk;
    logic rst_n;

    was_cfg_if cfg_if ();
    was_in_if  ts_if ();
    was_out_if alarm_if ();

    wake_alarm_scheduler u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_if),
        .timestamp (ts_if),
        .alarm     (alarm_if)
    );

    // Shadow copy of the configuration registers
    logic [MODE_W-1:0]     cur_mode;
    logic [INTERVAL_W-1:0] cur_interval;
    logic [ANCHOR_W-1:0]   cur_anchor;
    logic [HOUR_W-1:0]     cur_hour;
    logic [MINUTE_W-1:0]   cur_minute;

    alarm_fields_t expected_alarms[$];
    int error_count;
    int cycle_count;
    int rx_hold_cycles;
    bit tx_no_idle;
    bit rx_no_idle;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] to_bcd(input logic [31:0] v);
        return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    // Next alarm instant and its BCD bytes for one timestamp
    function automatic alarm_fields_t predict_alarm(input logic [NOW_W-1:0] now);
        logic [31:0]   period;
        logic [31:0]   slot;
        logic [31:0]   slot_count;
        logic [31:0]   near_limit;
        logic [31:0]   day_start;
        logic [31:0]   t;
        logic [7:0]    bcd_val;
        logic          ok;
        alarm_fields_t r;
        period = {16'd0, cur_interval} * 32'd60;
        ok     = 1'b1;
        t      = '0;
        slot   = '0;
        case (cur_mode)
            MODE_SYNC:
            begin
                if (cur_anchor != 0 && cur_interval != 0)
                begin
                    if (now < cur_anchor)
                        slot = cur_anchor;
                    else
                    begin
                        slot_count = (now - cur_anchor) / period;
                        slot = cur_anchor + (slot_count + 32'd1) * period;
                    end
                end
                else
                    slot = now + period;
                // wake early, but never wrap below zero
                if (slot > 32'(PRE_WAKE))
                    slot = slot - 32'(PRE_WAKE);
                near_limit = now + 32'(NEAR_WINDOW);
                if (slot <= near_limit)
                    slot = slot + period;
                t = slot;
            end
            MODE_RESCUE:
            begin
                if (cur_interval == 0)
                    ok = 1'b0;
                else
                    t = now + period;
            end
            MODE_DAILY:
            begin
                day_start = now - (now % 32'(SECS_PER_DAY));
                t = day_start + {27'd0, cur_hour} * 32'd3600
                    + {26'd0, cur_minute} * 32'd60;
                if (t <= now)
                    t = t + 32'(SECS_PER_DAY);
            end
            default: ok = 1'b0;
        endcase
        r = '0;
        if (ok)
        begin
            r.alarm_time   = t;
            bcd_val        = to_bcd(t % 60);
            r.seconds_byte = bcd_val[SEC_BYTE_W-1:0];
            bcd_val        = to_bcd((t / 60) % 60);
            r.minutes_byte = bcd_val[MIN_BYTE_W-1:0];
            bcd_val        = to_bcd((t / 3600) % 24);
            r.hours_byte   = bcd_val[HOUR_BYTE_W-1:0];
            r.scheduled    = 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
    endtask

    // Compare one alarm transaction against the oldest prediction
    task automatic check_alarm();
        alarm_fields_t want;
        if (expected_alarms.size() == 0)
            report_mismatch("alarm with nothing pending", alarm_if.alarm_time, '0);
        else
        begin
            want = expected_alarms.pop_front();
            if (alarm_if.alarm_time !== want.alarm_time)
                report_mismatch("alarm_time", alarm_if.alarm_time, want.alarm_time);
            if (alarm_if.seconds_byte !== want.seconds_byte)
                report_mismatch("seconds_byte", 32'(alarm_if.seconds_byte),
                                32'(want.seconds_byte));
            if (alarm_if.minutes_byte !== want.minutes_byte)
                report_mismatch("minutes_byte", 32'(alarm_if.minutes_byte),
                                32'(want.minutes_byte));
            if (alarm_if.hours_byte !== want.hours_byte)
                report_mismatch("hours_byte", 32'(alarm_if.hours_byte),
                                32'(want.hours_byte));
            if (alarm_if.scheduled !== want.scheduled)
                report_mismatch("scheduled", 32'(alarm_if.scheduled),
                                32'(want.scheduled));
        end
    endtask

    // Alarm receiver: random stalls, optional long hold-off, checks each result
    initial
    begin
        int stall;
        alarm_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                alarm_if.ready <= 1'b0;
                repeat (rx_hold_cycles) @(negedge clk);
                rx_hold_cycles = 0;
            end
            stall = rx_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0)
            begin
                alarm_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            alarm_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!alarm_if.valid);
            check_alarm();
        end
    end

    // Send one timestamp; called and returning at a falling edge
    task automatic send_timestamp(input logic [NOW_W-1:0] now);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            ts_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        ts_if.now_seconds <= now;
        ts_if.valid       <= 1'b1;
        do
            @(posedge clk);
        while (!ts_if.ready);
        expected_alarms.push_back(predict_alarm(now));
        @(negedge clk);
    endtask

    // Stop offering timestamps until every pending alarm has come back
    task automatic wait_drained();
        ts_if.valid <= 1'b0;
        while (expected_alarms.size() != 0)
            @(negedge clk);
    endtask

    // Write all five registers back to back while the block is idle
    task automatic set_config(input logic [MODE_W-1:0] mode,
                              input logic [INTERVAL_W-1:0] interval,
                              input logic [ANCHOR_W-1:0] anchor,
                              input logic [HOUR_W-1:0] hour,
                              input logic [MINUTE_W-1:0] minute);
        logic [CFG_INDEX_W-1:0] reg_index [5];
        logic [CFG_DATA_W-1:0]  reg_data [5];
        reg_index = '{CFG_MODE, CFG_INTERVAL, CFG_ANCHOR, CFG_HOUR, CFG_MINUTE};
        reg_data  = '{32'(mode), 32'(interval), anchor, 32'(hour), 32'(minute)};
        wait_drained();
        for (int i = 0; i < 5; i++)
        begin
            cfg_if.index <= reg_index[i];
            cfg_if.data  <= reg_data[i];
            cfg_if.valid <= 1'b1;
            do
                @(posedge clk);
            while (!cfg_if.ready);
            case (reg_index[i])
                CFG_MODE:     cur_mode     = reg_data[i][MODE_W-1:0];
                CFG_INTERVAL: cur_interval = reg_data[i][INTERVAL_W-1:0];
                CFG_ANCHOR:   cur_anchor   = reg_data[i][ANCHOR_W-1:0];
                CFG_HOUR:     cur_hour     = reg_data[i][HOUR_W-1:0];
                CFG_MINUTE:   cur_minute   = reg_data[i][MINUTE_W-1:0];
                default: ;
            endcase
            @(negedge clk);
        end
        cfg_if.valid <= 1'b0;
    endtask

    // Registers at their reset values: sync with no interval and no anchor
    task automatic test_reset_defaults();
        send_timestamp(32'd0);
        send_timestamp(32'd10);
        send_timestamp(32'd11);
        send_timestamp(32'hFFFF_FFFF);
    endtask

    // Sync slots: no anchor, before/at anchor, closeness boundary, wrap
    task automatic test_sync_mode();
        set_config(MODE_SYNC, 16'd1, 32'd0, 5'd0, 6'd0);
        send_timestamp(32'd1000);
        send_timestamp(32'hFFFF_FFF0);
        set_config(MODE_SYNC, 16'd10, 32'd1_000_000, 5'd0, 6'd0);
        send_timestamp(32'd999_999);
        send_timestamp(32'd1_000_000);
        send_timestamp(32'd1_000_584);
        send_timestamp(32'd1_000_585);
        send_timestamp(32'd1_000_599);
        send_timestamp(32'd1_000_600);
        set_config(MODE_SYNC, 16'hFFFF, 32'hFFFF_FFFF, 5'd0, 6'd0);
        send_timestamp(32'hFFFF_FFFE);
        send_timestamp(32'hFFFF_FFFF);
        send_timestamp(32'd0);
    endtask

    // Rescue: zero interval rejected, largest interval wraps
    task automatic test_rescue_mode();
        set_config(MODE_RESCUE, 16'd0, 32'd0, 5'd0, 6'd0);
        send_timestamp(32'd12345);
        set_config(MODE_RESCUE, 16'hFFFF, 32'd0, 5'd0, 6'd0);
        send_timestamp(32'hFFFF_FFFF);
        send_timestamp(32'd0);
        set_config(MODE_RESCUE, 16'd1, 32'd0, 5'd0, 6'd0);
        send_timestamp(32'd86399);
    endtask

    // Daily: midnight, last minute of the day, hour and minute out of range
    task automatic test_daily_mode();
        set_config(MODE_DAILY, 16'd7, 32'd12345, 5'd0, 6'd0);
        send_timestamp(32'd0);
        send_timestamp(32'd86399);
        set_config(MODE_DAILY, 16'd0, 32'd0, 5'd23, 6'd59);
        send_timestamp(32'd86340);
        send_timestamp(32'd86339);
        set_config(MODE_DAILY, 16'd0, 32'd0, 5'd31, 6'd63);
        send_timestamp(32'hFFFF_FFFF);
    endtask

    // Fourth mode code is rejected like a zero rescue interval
    task automatic test_unused_mode();
        set_config(MODE_UNUSED, 16'd5, 32'd100, 5'd12, 6'd30);
        send_timestamp(32'd777);
        send_timestamp(32'hFFFF_FFFF);
    endtask

    // Random settings per phase, timestamps aimed at slot and day boundaries
    task automatic test_random_traffic();
        logic [MODE_W-1:0]     mode;
        logic [INTERVAL_W-1:0] interval;
        logic [ANCHOR_W-1:0]   anchor;
        logic [HOUR_W-1:0]     hour;
        logic [MINUTE_W-1:0]   minute;
        logic [31:0]           period;
        logic [31:0]           now;
        int                    pick;
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 7)
                mode = MODE_SYNC;
            else if (pick < 12)
                mode = MODE_RESCUE;
            else if (pick < 18)
                mode = MODE_DAILY;
            else
                mode = MODE_UNUSED;
            case ($urandom_range(0, 4))
                0:       interval = 16'd0;
                1:       interval = 16'($urandom_range(1, 10));
                2:       interval = 16'hFFFF;
                default: interval = 16'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 3))
                0:       anchor = 32'd0;
                1:       anchor = 32'hFFFF_FFFF - $urandom_range(0, 1000);
                default: anchor = $urandom();
            endcase
            hour   = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(24, 31))
                                                 : 5'($urandom_range(0, 23));
            minute = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(60, 63))
                                                 : 6'($urandom_range(0, 59));
            set_config(mode, interval, anchor, hour, minute);
            // some phases run back to back on one or both sides
            tx_no_idle = (phase % 5 == 4) || (phase % 7 == 3);
            rx_no_idle = (phase % 5 == 4);
            period = {16'd0, cur_interval} * 32'd60;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                case ($urandom_range(0, 5))
                    0, 1:
                        now = $urandom();
                    2:
                        now = cur_anchor + $urandom_range(0, 3) * period
                              + $urandom_range(0, 40) - 32'd20;
                    3:
                        now = ($urandom() / 32'(SECS_PER_DAY)) * 32'(SECS_PER_DAY)
                              + {27'd0, cur_hour} * 32'd3600
                              + {26'd0, cur_minute} * 32'd60
                              + $urandom_range(0, 4) - 32'd2;
                    4:
                        now = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 20))
                              : 32'hFFFF_FFFF - $urandom_range(0, 20);
                    default:
                        now = $urandom() & 32'h000F_FFFF;
                endcase
                send_timestamp(now);
            end
        end
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
    endtask

    // Long receiver hold-off with the sender flat out, then a full drain and more timestamps
    task automatic test_backpressure();
        set_config(MODE_SYNC, 16'd3, 32'd5000, 5'd6, 6'd15);
        rx_hold_cycles = 300;
        tx_no_idle     = 1'b1;
        for (int n = 0; n < 80; n++)
            send_timestamp($urandom());
        tx_no_idle = 1'b0;
        wait_drained();
        for (int n = 0; n < 40; n++)
            send_timestamp($urandom());
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        cfg_if.valid       <= 1'b0;
        cfg_if.index       <= '0;
        cfg_if.data        <= '0;
        ts_if.valid        <= 1'b0;
        ts_if.now_seconds  <= '0;
        cur_mode     = '0;
        cur_interval = '0;
        cur_anchor   = '0;
        cur_hour     = '0;
        cur_minute   = '0;
        error_count    = 0;
        cycle_count    = 0;
        rx_hold_cycles = 0;
        tx_no_idle     = 1'b0;
        rx_no_idle     = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_sync_mode();
        test_rescue_mode();
        test_daily_mode();
        test_unused_mode();
        test_random_traffic();
        test_backpressure();

        // let any stray transaction show up before the verdict
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
sv/was_pkg.sv
sv/was_in_if.sv
sv/was_out_if.sv
sv/was_cfg_if.sv
sv/was_div.sv
sv/was_tod.sv
sv/wake_alarm_scheduler.sv
verif/wake_alarm_scheduler_tb.sv
